### rtl/mlfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_pkg
// Shared types, constants and the gamma curve for the LED fade engine.
// ----------------------------------------------------------------------------
package mlfe_pkg;

  localparam int CHANNELS_DEF   = 16;
  localparam int LEVEL_BITS_DEF = 12;
  localparam int CH_W           = 4;
  localparam int OUT_LVL_W      = 12;
  localparam int IDX_W          = 5;
  localparam int IN_LVL_W       = 16;
  localparam int TIME_W         = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_RGB_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_COUNT = 1'd1;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_CHAN_FADE  = 3'd1,
    KIND_SINGLE     = 3'd2,
    KIND_RGB        = 3'd3,
    KIND_ALL_SINGLE = 3'd4,
    KIND_ALL_RGB    = 3'd5,
    KIND_RSV6       = 3'd6,
    KIND_RSV7       = 3'd7
  } kind_t;

  // Command after classification: a channel range and a target pattern.
  typedef struct packed {
    logic        tick;
    logic        stop_low;     // clear active bits of channels below stop_end
    logic [5:0]  stop_end;
    logic [5:0]  first_ch;
    logic [5:0]  count;        // channels to visit
    logic        rgb_pattern;  // cycle targets red, green, blue
    logic [15:0] lvl_r;
    logic [15:0] lvl_g;
    logic [15:0] lvl_b;
    logic [31:0] now_ms;
    logic [31:0] duration_ms;
  } cmd_t;

  // gamma 2.2: largest g with g^5 * M^6 <= i^11, M = 4095, in integer math.
  function automatic logic [11:0] gamma_calc(input int unsigned i);
    logic [131:0] rhs;
    logic [131:0] lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = 132'd1;
    for (int t = 0; t < 11; t++) rhs = rhs * 132'(i);
    lo = 0;
    hi = 4095;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 132'd1;
      for (int t = 0; t < 5; t++) lhs = lhs * 132'(mid);
      for (int t = 0; t < 6; t++) lhs = lhs * 132'd4095;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 12'(lo);
  endfunction

endpackage

### rtl/mlfe_gamma_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_gamma_rom
// Constant gamma 2.2 table with a registered read.
// ----------------------------------------------------------------------------
module mlfe_gamma_rom (
  input  logic        clk,
  input  logic [11:0] addr,
  output logic [11:0] data
);

  logic [11:0] rom [4096];

  always_comb begin
    for (int i = 0; i < 4096; i++) rom[i] = mlfe_pkg::gamma_calc(i);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

### rtl/mlfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_front
// Accepts items, resolves LED addressing into a channel range, and queues
// the resulting commands for the fade executor.
// ----------------------------------------------------------------------------
module mlfe_front #(
  parameter int CHANNELS = mlfe_pkg::CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  ready,
  input  logic [2:0]            kind,
  input  logic [31:0]           now_ms,
  input  logic [4:0]            target_index,
  input  logic [15:0]           level_one,
  input  logic [15:0]           level_green,
  input  logic [15:0]           level_blue,
  input  logic [31:0]           duration_ms,
  input  logic [2:0]            rgb_cnt,
  input  logic [4:0]            single_cnt,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output mlfe_pkg::cmd_t        cmd
);

  localparam int DEPTH = 2;

  mlfe_pkg::cmd_t q [DEPTH];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] fill;

  mlfe_pkg::cmd_t c;
  logic           keep;
  logic [5:0]     rgb, single, rgb3;

  always_comb begin
    rgb3   = 6'(rgb_cnt) * 6'd3;
    rgb    = 6'(rgb_cnt);
    single = 6'(single_cnt);
    if (7'(rgb3) + 7'(single_cnt) > 7'(CHANNELS)) begin
      rgb = '0;
      single = '0;
      rgb3 = '0;
    end
    c = '0;
    c.now_ms = now_ms;
    c.duration_ms = duration_ms;
    c.lvl_r = level_one;
    c.lvl_g = level_green;
    c.lvl_b = level_blue;
    keep = 1'b0;
    case (mlfe_pkg::kind_t'(kind))
      mlfe_pkg::KIND_TICK: begin
        keep = 1'b1;
        c.tick = 1'b1;
        c.count = 6'(CHANNELS);
      end
      mlfe_pkg::KIND_CHAN_FADE: begin
        keep = 6'(target_index) < 6'(CHANNELS);
        c.first_ch = 6'(target_index);
        c.count = 6'd1;
      end
      mlfe_pkg::KIND_SINGLE: begin
        keep = 6'(target_index) < single;
        c.first_ch = rgb3 + 6'(target_index);
        c.count = 6'd1;
      end
      mlfe_pkg::KIND_RGB: begin
        keep = 6'(target_index) < rgb;
        c.first_ch = 6'(target_index) * 6'd3;
        c.count = 6'd3;
        c.rgb_pattern = 1'b1;
      end
      mlfe_pkg::KIND_ALL_SINGLE: begin
        keep = 1'b1;
        c.stop_low = 1'b1;
        c.stop_end = rgb3;
        c.first_ch = rgb3;
        c.count = single;
      end
      mlfe_pkg::KIND_ALL_RGB: begin
        keep = 1'b1;
        c.count = rgb3;
        c.rgb_pattern = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  logic push, pop;
  assign ready     = fill != 2'(DEPTH);
  assign push      = valid && ready && keep;
  assign cmd_valid = fill != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'(DEPTH))
    else $error("queue overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    fill == 2'(DEPTH) && !pop |=> fill == 2'(DEPTH))
    else $error("full queue changed without pop");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 && !push |=> !cmd_valid)
    else $error("queue valid from nothing");

endmodule

### rtl/mlfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfe_back
// Walks the channels of one command: interpolates with a serial divider,
// updates fade state, and emits gamma-corrected levels.
// ----------------------------------------------------------------------------
module mlfe_back #(
  parameter int CHANNELS = mlfe_pkg::CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  mlfe_pkg::cmd_t        cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            channel,
  output logic [11:0]           linear_level,
  output logic [11:0]           pwm_duty,
  output logic                  last
);

  localparam int CW = $clog2(CHANNELS) > 0 ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_NEXT, S_DIV, S_APPLY, S_ROM, S_OUT} state_t;
  state_t state;

  logic [11:0] fade_from   [CHANNELS];
  logic [11:0] fade_to     [CHANNELS];
  logic [31:0] fade_began  [CHANNELS];
  logic [31:0] fade_length [CHANNELS];
  logic [CHANNELS-1:0] fading;

  mlfe_pkg::cmd_t cur;
  logic [5:0]  pos;          // channels visited so far
  logic [1:0]  color;
  logic [5:0]  ch;
  logic [11:0] tgt;
  logic        have_pend;    // a result is held for emission (last unknown)
  logic [3:0]  pend_ch;
  logic [11:0] pend_lvl;

  // divider: |delta| * elapsed / length, 44-bit numerator
  logic [43:0] num;
  logic [31:0] rem;
  logic [5:0]  dcnt;
  logic        neg;
  logic [11:0] base;

  logic [CW-1:0] chi;
  assign chi = ch[CW-1:0];

  logic [31:0] elapsed;
  logic        done_fade;
  assign elapsed   = cur.now_ms - fade_began[chi];
  assign done_fade = !fading[chi] || elapsed >= fade_length[chi] || fade_length[chi] == 0;

  logic [15:0] raw_t;
  always_comb begin
    case (color)
      2'd1:    raw_t = cur.lvl_g;
      2'd2:    raw_t = cur.lvl_b;
      default: raw_t = cur.lvl_r;
    endcase
    tgt = raw_t > 16'd4095 ? 12'd4095 : raw_t[11:0];
  end

  logic [32:0] trial;
  assign trial = {rem, num[43]} - {1'b0, fade_length[chi]};

  logic [11:0] rom_addr, rom_data;
  mlfe_gamma_rom u_rom (.clk(clk), .addr(rom_addr), .data(rom_data));

  logic [11:0] res_lvl;
  logic        emit_now;
  logic        emit_last;
  logic [3:0]  out_ch_hold;

  // ticks and immediate writes produce a result; timed fades only update state
  assign emit_now = cur.tick || cur.duration_ms == 32'd0;

  assign cmd_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fading <= '0;
      out_valid <= 1'b0;
      have_pend <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fade_from[i] <= '0;
        fade_to[i] <= '0;
        fade_began[i] <= '0;
        fade_length[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          pos <= '0;
          color <= '0;
          ch <= cmd.first_ch;
          if (cmd.stop_low) begin
            for (int i = 0; i < CHANNELS; i++)
              if (6'(i) < cmd.stop_end) fading[i] <= 1'b0;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (pos == cur.count) begin
            if (have_pend) begin
              emit_last <= 1'b1;
              state <= S_ROM;
              rom_addr <= pend_lvl;
            end else state <= S_IDLE;
          end else if (cur.tick && !fading[chi]) begin
            pos <= pos + 6'd1;
            ch <= ch + 6'd1;
          end else if (!cur.tick && cur.duration_ms == 0) begin
            fading[chi] <= 1'b0;
            fade_from[chi] <= tgt;
            fade_to[chi] <= tgt;
            res_lvl <= tgt;
            state <= S_APPLY;
          end else if (done_fade) begin
            res_lvl <= fade_to[chi];
            state <= S_APPLY;
          end else begin
            neg <= fade_to[chi] < fade_from[chi];
            base <= fade_from[chi];
            num <= 44'((fade_to[chi] < fade_from[chi] ?
                        fade_from[chi] - fade_to[chi] : fade_to[chi] - fade_from[chi]))
                   * 44'(elapsed);
            rem <= '0;
            dcnt <= 6'd44;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == 0) begin
            // quotient below |delta| so the result stays in range
            res_lvl <= neg ? base - num[11:0] : base + num[11:0];
            state <= S_APPLY;
          end else begin
            if (!trial[32]) begin
              rem <= trial[31:0];
              num <= {num[42:0], 1'b1};
            end else begin
              rem <= {rem[30:0], num[43]};
              num <= {num[42:0], 1'b0};
            end
            dcnt <= dcnt - 6'd1;
          end
        end
        S_APPLY: begin
          if (cur.tick) begin
            if (res_lvl == fade_to[chi]) fading[chi] <= 1'b0;
          end else if (!emit_now) begin
            fade_from[chi] <= res_lvl;
            fade_to[chi] <= tgt;
            fade_began[chi] <= cur.now_ms;
            fade_length[chi] <= cur.duration_ms;
            fading[chi] <= 1'b1;
          end
          pos <= pos + 6'd1;
          ch <= ch + 6'd1;
          color <= (cur.rgb_pattern && color != 2'd2) ? color + 2'd1 : 2'd0;
          if (emit_now) begin
            pend_ch <= 4'(ch);
            pend_lvl <= res_lvl;
            if (have_pend) begin
              emit_last <= 1'b0;
              rom_addr <= pend_lvl;
              state <= S_ROM;
            end else begin
              have_pend <= 1'b1;
              state <= S_NEXT;
            end
          end else state <= S_NEXT;
        end
        S_ROM: if (!out_valid || out_ready) begin
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          last <= emit_last;
          pwm_duty <= rom_data;
          linear_level <= rom_addr;
          // older pending item is out; the new one (if any) sits in pend_*
          if (emit_last) begin
            have_pend <= 1'b0;
            channel <= pend_ch;
            state <= S_IDLE;
          end else begin
            channel <= out_ch_hold;
            state <= S_NEXT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // channel of the older result, captured when it is displaced
  always_ff @(posedge clk) begin
    if (state == S_APPLY && emit_now && have_pend) out_ch_hold <= pend_ch;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel))
    else $error("result dropped");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !have_pend)
    else $error("pending result stranded");
  a_rom_space: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !out_valid || $past(out_ready))
    else $error("result overwritten");

endmodule

### rtl/multichannel_led_fade_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_led_fade_engine
// Per-channel linear LED fades with gamma-corrected PWM duty output.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | valid / ready      | kind now_ms target_index level_* duration_ms
//  out     | out_valid/out_ready| channel linear_level pwm_duty last
//  cfg     | cfg_we             | cfg_index cfg_data
// A command leaves the queue only while the executor is idle; a tick skips each
// channel that is not fading, and a visited channel goes through the serial
// divider when its fade is mid-way. A result then passes the gamma ROM read and
// the output register, and waits there while the output stalls.
// Reset is synchronous and clears all fade state and both counts.
// A two-entry command queue lets input items arrive while results stall.
module multichannel_led_fade_engine #(
  parameter int CHANNELS = mlfe_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  kind,
  input  logic [31:0] now_ms,
  input  logic [4:0]  target_index,
  input  logic [15:0] level_one,
  input  logic [15:0] level_green,
  input  logic [15:0] level_blue,
  input  logic [31:0] duration_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  channel,
  output logic [11:0] linear_level,
  output logic [11:0] pwm_duty,
  output logic        last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [2:0] rgb_cnt;
  logic [4:0] single_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_cnt <= '0;
      single_cnt <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfe_pkg::REG_RGB_COUNT:    rgb_cnt <= cfg_data[2:0];
        mlfe_pkg::REG_SINGLE_COUNT: single_cnt <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           cmd_valid, cmd_ready;
  mlfe_pkg::cmd_t cmd;

  mlfe_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .valid, .ready, .kind, .now_ms, .target_index, .level_one,
    .level_green, .level_blue, .duration_ms, .rgb_cnt, .single_cnt,
    .cmd_valid, .cmd_ready, .cmd
  );

  mlfe_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
    .channel, .linear_level, .pwm_duty, .last
  );

endmodule

### verif/tb_multichannel_led_fade_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_led_fade_engine
// Drives fade commands and ticks through several LED layouts, predicts every
// channel write (interpolated level, gamma duty, last flag) and checks each
// result in order against the prediction, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_multichannel_led_fade_engine;

  localparam int NCH = 16;
  localparam logic [11:0] LVL_MAX = 12'd4095;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [4:0]  target_index;
    logic [15:0] level_one;
    logic [15:0] level_green;
    logic [15:0] level_blue;
    logic [31:0] duration_ms;
  } cmd_item_t;

  typedef struct {
    logic [3:0]  channel;
    logic [11:0] linear_level;
    logic [11:0] pwm_duty;
    logic        last;
  } duty_write_t;

  typedef struct {
    cmd_item_t   cmd;
    int          typed_count;  // -1: use the predictor only
    duty_write_t typed;
  } stim_row_t;

  logic clk;
  logic rst;
  logic valid;
  logic ready;
  logic [2:0]  kind;
  logic [31:0] now_ms;
  logic [4:0]  target_index;
  logic [15:0] level_one;
  logic [15:0] level_green;
  logic [15:0] level_blue;
  logic [31:0] duration_ms;
  logic out_valid;
  logic out_ready;
  logic [3:0]  channel;
  logic [11:0] linear_level;
  logic [11:0] pwm_duty;
  logic last;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [4:0] cfg_data;

  multichannel_led_fade_engine i_dut (
    .clk(clk), .rst(rst),
    .valid(valid), .ready(ready),
    .kind(kind), .now_ms(now_ms), .target_index(target_index),
    .level_one(level_one), .level_green(level_green), .level_blue(level_blue),
    .duration_ms(duration_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .channel(channel), .linear_level(linear_level), .pwm_duty(pwm_duty),
    .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow fade state
  logic [11:0] sh_from  [NCH];
  logic [11:0] sh_to    [NCH];
  logic [31:0] sh_began [NCH];
  logic [31:0] sh_len   [NCH];
  logic        sh_fading[NCH];
  logic [11:0] gamma_curve[4096];
  logic [2:0]  sh_rgb;
  logic [4:0]  sh_single;

  duty_write_t pending_writes[$];
  int  errors;
  bit  calm;
  bit  hold_go;
  int  stall_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gamma 2.2 curve: largest g with g^5 * 4095^6 <= i^11; g never decreases.
  task automatic build_gamma();
    logic [131:0] m6;
    logic [131:0] rhs;
    logic [131:0] lhs;
    int g;
    m6 = 132'd1;
    for (int t = 0; t < 6; t++) m6 = m6 * 132'd4095;
    g = 0;
    for (int i = 0; i < 4096; i++) begin
      rhs = 132'd1;
      for (int t = 0; t < 11; t++) rhs = rhs * 132'(i);
      forever begin
        if (g >= 4095) break;
        lhs = 132'd1;
        for (int t = 0; t < 5; t++) lhs = lhs * 132'(g + 1);
        lhs = lhs * m6;
        if (lhs <= rhs) g++;
        else break;
      end
      gamma_curve[i] = 12'(g);
    end
  endtask

  function automatic logic [11:0] clamp_level(logic [15:0] v);
    return (v > 16'(LVL_MAX)) ? LVL_MAX : v[11:0];
  endfunction

  function automatic logic [11:0] level_now(int ch, logic [31:0] t);
    logic [31:0] elapsed;
    longint start;
    longint delta;
    longint v;
    if (!sh_fading[ch]) return sh_to[ch];
    elapsed = t - sh_began[ch];
    if (elapsed >= sh_len[ch] || sh_len[ch] == 32'd0) return sh_to[ch];
    start = longint'(sh_from[ch]);
    delta = longint'(sh_to[ch]) - start;
    v = start + (delta * longint'(elapsed)) / longint'(sh_len[ch]);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic void queue_write(int ch, logic [11:0] lvl);
    duty_write_t w;
    w.channel = 4'(ch);
    w.linear_level = lvl;
    w.pwm_duty = gamma_curve[lvl];
    w.last = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void start_fade(int ch, logic [11:0] target, logic [31:0] dur,
                                     logic [31:0] t);
    if (ch >= NCH) return;
    if (dur == 32'd0) begin
      sh_fading[ch] = 1'b0;
      sh_from[ch] = target;
      sh_to[ch] = target;
      queue_write(ch, target);
      return;
    end
    sh_from[ch] = level_now(ch, t);
    sh_to[ch] = target;
    sh_began[ch] = t;
    sh_len[ch] = dur;
    sh_fading[ch] = 1'b1;
  endfunction

  function automatic void predict_writes(cmd_item_t c);
    int rgb;
    int single;
    int base;
    int n0;
    logic [11:0] l1;
    logic [11:0] lg;
    logic [11:0] lb;
    logic [11:0] lvl;
    n0 = pending_writes.size();
    rgb = sh_rgb;
    single = sh_single;
    if (rgb * 3 + single > NCH) begin
      rgb = 0;
      single = 0;
    end
    l1 = clamp_level(c.level_one);
    lg = clamp_level(c.level_green);
    lb = clamp_level(c.level_blue);
    case (c.kind)
      mlfe_pkg::KIND_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (sh_fading[i]) begin
            lvl = level_now(i, c.now_ms);
            if (lvl == sh_to[i]) sh_fading[i] = 1'b0;
            queue_write(i, lvl);
          end
        end
      end
      mlfe_pkg::KIND_CHAN_FADE:
        start_fade(int'(c.target_index), l1, c.duration_ms, c.now_ms);
      mlfe_pkg::KIND_SINGLE: begin
        if (int'(c.target_index) < single)
          start_fade(rgb * 3 + int'(c.target_index), l1, c.duration_ms, c.now_ms);
      end
      mlfe_pkg::KIND_RGB: begin
        if (int'(c.target_index) < rgb) begin
          base = int'(c.target_index) * 3;
          start_fade(base, l1, c.duration_ms, c.now_ms);
          start_fade(base + 1, lg, c.duration_ms, c.now_ms);
          start_fade(base + 2, lb, c.duration_ms, c.now_ms);
        end
      end
      mlfe_pkg::KIND_ALL_SINGLE: begin
        // stop RGB fades before touching the singles
        for (int i = 0; i < rgb * 3 && i < NCH; i++) sh_fading[i] = 1'b0;
        for (int i = 0; i < single; i++)
          start_fade(rgb * 3 + i, l1, c.duration_ms, c.now_ms);
      end
      mlfe_pkg::KIND_ALL_RGB: begin
        for (int i = 0; i < rgb; i++) begin
          start_fade(i * 3, l1, c.duration_ms, c.now_ms);
          start_fade(i * 3 + 1, lg, c.duration_ms, c.now_ms);
          start_fade(i * 3 + 2, lb, c.duration_ms, c.now_ms);
        end
      end
      default: ;
    endcase
    if (pending_writes.size() > n0)
      pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(cmd_item_t c);
    while (!calm && $urandom_range(0, 99) < 13) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    kind <= c.kind;
    now_ms <= c.now_ms;
    target_index <= c.target_index;
    level_one <= c.level_one;
    level_green <= c.level_green;
    level_blue <= c.level_blue;
    duration_ms <= c.duration_ms;
    // ready is sampled as it stood just before the edge
    @(posedge clk iff ready);
  endtask

  // Drop valid, drain every write, then let trailing state updates finish.
  task automatic drain_writes();
    valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mlfe_pkg::REG_RGB_COUNT) sh_rgb = data[2:0];
    else sh_single = data;
    @(posedge clk);
  endtask

  function automatic cmd_item_t make_cmd(logic [2:0] k, logic [31:0] t, logic [4:0] idx,
                                         logic [15:0] l1, logic [15:0] lg,
                                         logic [15:0] lb, logic [31:0] dur);
    cmd_item_t c;
    c.kind = k;
    c.now_ms = t;
    c.target_index = idx;
    c.level_one = l1;
    c.level_green = lg;
    c.level_blue = lb;
    c.duration_ms = dur;
    return c;
  endfunction

  function automatic logic [15:0] rand_level();
    if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 4095));
    return 16'($urandom_range(0, 65535));
  endfunction

  // Result checker
  always @(posedge clk) begin
    duty_write_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected result: channel %0d level %0d", channel, linear_level);
        errors++;
      end else begin
        w = pending_writes.pop_front();
        if (channel !== w.channel) begin
          $error("channel: expected %0d, got %0d", w.channel, channel);
          errors++;
        end
        if (linear_level !== w.linear_level) begin
          $error("linear_level: expected %0d, got %0d", w.linear_level, linear_level);
          errors++;
        end
        if (pwm_duty !== w.pwm_duty) begin
          $error("pwm_duty: expected %0d, got %0d", w.pwm_duty, pwm_duty);
          errors++;
        end
        if (last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    cmd_item_t c;
    int n0;
    int k;
    int pick;
    logic [31:0] t;
    logic [4:0] reg_rgb[8];
    logic [4:0] reg_single[8];

    rst = 1'b1;
    valid = 1'b0;
    kind = '0;
    now_ms = '0;
    target_index = '0;
    level_one = '0;
    level_green = '0;
    level_blue = '0;
    duration_ms = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    stall_count = 0;
    sh_rgb = '0;
    sh_single = '0;
    for (int i = 0; i < NCH; i++) begin
      sh_from[i] = '0;
      sh_to[i] = '0;
      sh_began[i] = '0;
      sh_len[i] = '0;
      sh_fading[i] = 1'b0;
    end
    build_gamma();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; counts are zero after reset
    r.typed = '{4'd0, 12'd0, 12'd0, 1'b1};
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'd0, 5'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd1, 5'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    r.typed_count = 1; r.typed = '{4'd0, 12'd0, 12'd0, 1'b1}; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd2, 5'd15, 16'hFFFF, 16'd0, 16'd0,
                     32'd0);
    r.typed_count = 1; r.typed = '{4'd15, 12'd4095, 12'd4095, 1'b1}; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd3, 5'd1, 16'd4095, 16'd0, 16'd0,
                     32'd0);
    r.typed_count = 1; r.typed = '{4'd1, 12'd4095, 12'd4095, 1'b1}; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd4, 5'd31, 16'd100, 16'd0, 16'd0,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd4, 5'd16, 16'd100, 16'd0, 16'd0,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_SINGLE, 32'd5, 5'd0, 16'd100, 16'd0, 16'd0, 32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_RGB, 32'd5, 5'd0, 16'd100, 16'd200, 16'd300, 32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_ALL_SINGLE, 32'd5, 5'd0, 16'd100, 16'd0, 16'd0,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_ALL_RGB, 32'd5, 5'd0, 16'd100, 16'd200, 16'd300,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_RSV6, 32'd6, 5'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_RSV7, 32'd6, 5'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     32'd0);
    r.typed_count = 0; rows.push_back(r);
    r.typed_count = -1;
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd10, 5'd3, 16'd4000, 16'd0, 16'd0,
                     32'd100);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'd10, 5'd15, 16'd0, 16'd0, 16'd0,
                     32'd7);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'd60, 5'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'd110, 5'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'hFFFF_FFF0, 5'd7, 16'hFFFF, 16'd0,
                     16'd0, 32'hFFFF_FFFF);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'h0000_0005, 5'd0, 16'd0, 16'd0, 16'd0,
                     32'd0);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_CHAN_FADE, 32'h8000_0000, 5'd7, 16'd0, 16'd0, 16'd0,
                     32'd50);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'h8000_0019, 5'd0, 16'd0, 16'd0, 16'd0,
                     32'd0);
    rows.push_back(r);
    r.cmd = make_cmd(mlfe_pkg::KIND_TICK, 32'hFFFF_FFFF, 5'd0, 16'd0, 16'd0, 16'd0,
                     32'd0);
    rows.push_back(r);

    foreach (rows[i]) begin
      send_item(rows[i].cmd);
      n0 = pending_writes.size();
      predict_writes(rows[i].cmd);
      if (rows[i].typed_count >= 0) begin
        if (pending_writes.size() - n0 != rows[i].typed_count) begin
          $error("row %0d: result count expected %0d, got %0d", i,
                 rows[i].typed_count, pending_writes.size() - n0);
          errors++;
        end else if (rows[i].typed_count == 1) begin
          pending_writes[pending_writes.size() - 1] = rows[i].typed;
        end
      end
    end
    drain_writes();

    // Layouts: valid ones, both extremes, and oversized ones that act as zero
    reg_rgb    = '{5'd5, 5'd0, 5'd5, 5'd2, 5'd4, 5'd5, 5'd1, 5'd3};
    reg_single = '{5'd1, 5'd16, 5'd16, 5'd10, 5'd4, 5'd0, 5'd13, 5'd7};
    t = 32'd1000;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(mlfe_pkg::REG_RGB_COUNT, reg_rgb[ph]);
      write_reg(mlfe_pkg::REG_SINGLE_COUNT, reg_single[ph]);
      if (ph == 6) t = 32'hFFFF_FF00;
      calm = (ph == 4);
      for (int n = 0; n < 38; n++) begin
        if (ph == 2 && n == 5) hold_go = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 35) k = mlfe_pkg::KIND_TICK;
        else if (pick < 50) k = mlfe_pkg::KIND_CHAN_FADE;
        else if (pick < 62) k = mlfe_pkg::KIND_SINGLE;
        else if (pick < 75) k = mlfe_pkg::KIND_RGB;
        else if (pick < 84) k = mlfe_pkg::KIND_ALL_SINGLE;
        else if (pick < 94) k = mlfe_pkg::KIND_ALL_RGB;
        else k = $urandom_range(mlfe_pkg::KIND_RSV6, mlfe_pkg::KIND_RSV7);
        if ($urandom_range(0, 49) == 0) t = $urandom;
        else t = t + 32'($urandom_range(0, 60));
        c.kind = 3'(k);
        c.now_ms = t;
        c.target_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 15));
        if (k == mlfe_pkg::KIND_SINGLE && $urandom_range(0, 3) != 0)
          c.target_index = 5'($urandom_range(0, 16));
        if (k == mlfe_pkg::KIND_RGB && $urandom_range(0, 3) != 0)
          c.target_index = 5'($urandom_range(0, 5));
        c.level_one = rand_level();
        c.level_green = rand_level();
        c.level_blue = rand_level();
        pick = $urandom_range(0, 99);
        if (pick < 25) c.duration_ms = 32'd0;
        else if (pick < 85) c.duration_ms = 32'($urandom_range(1, 150));
        else c.duration_ms = $urandom;
        send_item(c);
        predict_writes(c);
      end
      drain_writes();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
